// ===== rtl/sci_pkg.sv =====
package sci_pkg;

	// Field widths
	localparam int TEMP_W     = 16;
	localparam int SLOPE_W    = 16;
	localparam int MID_W      = 13;
	localparam int IMPACT_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_ENABLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGMOID_SLOPE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGMOID_MIDPOINT = 2'd2;

	// Reset values of the configuration registers
	localparam logic [SLOPE_W-1:0] SLOPE_RESET = 16'd256;

	// Datapath widths
	localparam int SUM_W     = TEMP_W + 2;   // clr - bak + bias
	localparam int MAG_W     = SUM_W - 1;    // |clr - bak + bias|
	localparam int DEP_RAW_W = TEMP_W + 1;   // obs - bak
	localparam int DEP_W     = 13;           // departure clamped to 100 K
	localparam int DEP_CAP   = 6400;
	localparam int DIFF_W    = MID_W + 1;    // departure - midpoint, signed
	localparam int ARG_PROD_W = SLOPE_W + DIFF_W;
	localparam int MEAN_W    = MAG_W;
	localparam int WGT_W     = 16;
	localparam int SCALED_W  = MEAN_W + WGT_W + 1;
	localparam int IMPACT_MAX = 65535;
	localparam logic [WGT_W-1:0] WEIGHT_FLOOR = 16'd6554;
	localparam int ROUND_HALF = 32768;

	// Sigmoid table; depth is a power of two between 32 and 4096
	localparam int SIG_DEPTH = 256;
	localparam int SIG_IDX_W = $clog2(SIG_DEPTH);

	// Index = floor(n*D/Q) + D/2 with Q = 25 * 2^20, so n*D/Q = n / (25 * 2^ARG_SHIFT)
	localparam int ARG_SHIFT = 20 - SIG_IDX_W;
	localparam int ARG_W     = ARG_PROD_W - ARG_SHIFT;
	localparam int HALF_SPAN = (SIG_DEPTH / 2) * 25;
	localparam int SPAN_W    = $clog2(2 * HALF_SPAN);

	// floor(x/25) as (x * RECIP_K) >> RECIP_SHIFT, exact for x below 2^24/9
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(((2 ** RECIP_SHIFT) + 24) / 25);

	// Item fields that ride along the pipeline
	typedef struct packed {
		logic              ok;
		logic [MEAN_W-1:0] mean;
	} sci_item_t;

	typedef logic [WGT_W-1:0] sig_rom_t [SIG_DEPTH];

	localparam longint unsigned Q30_ONE      = 64'd1073741824;
	localparam longint unsigned EXP_NEG1_Q30 = 64'd395007542;

	// Shift-subtract divide, used only while building the table
	function automatic longint unsigned sig_udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-x) for x in [0, 1), Q30, Taylor series through x^16
	function automatic longint unsigned sig_exp_frac(input longint unsigned x);
		longint unsigned term;
		longint unsigned sum;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (int k = 1; k <= 16; k++) begin
			term = sig_udiv((term * x) >> 30, longint'(k));
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	// Sigmoid at each bin center, unsigned Q0.16
	function automatic sig_rom_t sig_build_rom();
		sig_rom_t        rom;
		longint          n;
		longint unsigned mag;
		longint unsigned zq;
		longint unsigned whole;
		longint unsigned e;
		longint unsigned den;
		longint unsigned val;
		for (int i = 0; i < SIG_DEPTH; i++) begin
			n     = 2 * longint'(i) + 1 - longint'(SIG_DEPTH);
			mag   = (n < 0) ? longint'(-n) : longint'(n);
			zq    = mag << (33 - SIG_IDX_W);
			whole = zq >> 30;
			e     = sig_exp_frac(zq & (Q30_ONE - 1));
			for (int w = 0; w < 8; w++) begin
				if (longint'(w) < whole) begin
					e = (e * EXP_NEG1_Q30) >> 30;
				end
			end
			den = Q30_ONE + e;
			if (n >= 0) begin
				val = sig_udiv((64'd1 << 46) + (den >> 1), den);
			end else begin
				val = sig_udiv((e << 16) + (den >> 1), den);
			end
			if (val > 64'd65535) begin
				val = 64'd65535;
			end
			rom[i] = val[WGT_W-1:0];
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = sig_build_rom();

endpackage

// ===== rtl/symmetric_cloud_impact.sv =====
// Channel   Transfer on              Payload
// input     start & !busy            clear_sky_temp, background_temp, observed_temp,
//                                    bias_term, clear_sky_valid .. bias_valid
// result    done                     impact, impact_valid
// config    cfg_we                   cfg_index, cfg_data
//
// One sample set enters every cycle; busy is never raised.
// Each result appears on done after the five registered stages, in order,
// one per input, for one cycle only. The five stages are the departures,
// the slope multiply, the index multiply, the table read and the weight multiply.
// arst_n clears the stage valid bits and loads the register reset values.
// The receiver cannot stall, so nothing is held back in the pipeline.
module symmetric_cloud_impact
	import sci_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [TEMP_W-1:0]   clear_sky_temp,
	input  logic signed [TEMP_W-1:0]   background_temp,
	input  logic signed [TEMP_W-1:0]   observed_temp,
	input  logic signed [TEMP_W-1:0]   bias_term,
	input  logic                       clear_sky_valid,
	input  logic                       background_valid,
	input  logic                       observed_valid,
	input  logic                       bias_valid,
	output logic                       done,
	output logic        [IMPACT_W-1:0] impact,
	output logic                       impact_valid,
	input  logic                       cfg_we,
	input  logic        [CFG_IDX_W-1:0] cfg_index,
	input  logic        [CFG_DATA_W-1:0] cfg_data
);

	logic                        scale_enable_q;
	logic signed [SLOPE_W-1:0]   sigmoid_slope_q;
	logic        [MID_W-1:0]     sigmoid_midpoint_q;

	logic                         valid_s2;
	sci_item_t                    item_s2;
	logic signed [ARG_PROD_W-1:0] arg_s2;
	logic                         valid_s4;
	sci_item_t                    item_s4;
	logic        [WGT_W-1:0]      wgt_s4;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_enable_q     <= 1'b0;
			sigmoid_slope_q    <= SLOPE_RESET;
			sigmoid_midpoint_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCALE_ENABLE:     scale_enable_q     <= cfg_data[0];
				CFG_SIGMOID_SLOPE:    sigmoid_slope_q    <= cfg_data[SLOPE_W-1:0];
				CFG_SIGMOID_MIDPOINT: sigmoid_midpoint_q <= cfg_data[MID_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	sci_prep u_prep (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.clear_sky_temp   (clear_sky_temp),
		.background_temp  (background_temp),
		.observed_temp    (observed_temp),
		.bias_term        (bias_term),
		.clear_sky_valid  (clear_sky_valid),
		.background_valid (background_valid),
		.observed_valid   (observed_valid),
		.bias_valid       (bias_valid),
		.sigmoid_slope    (sigmoid_slope_q),
		.sigmoid_midpoint (sigmoid_midpoint_q),
		.valid_s2         (valid_s2),
		.item_s2          (item_s2),
		.arg_s2           (arg_s2)
	);

	sci_wlookup u_wlookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.arg_s2   (arg_s2),
		.valid_s4 (valid_s4),
		.item_s4  (item_s4),
		.wgt_s4   (wgt_s4)
	);

	sci_apply u_apply (
		.clk             (clk),
		.arst_n          (arst_n),
		.scale_enable    (scale_enable_q),
		.valid_s4        (valid_s4),
		.item_s4         (item_s4),
		.wgt_s4          (wgt_s4),
		.done_s5         (done),
		.impact_s5       (impact),
		.impact_valid_s5 (impact_valid)
	);

endmodule

// ===== rtl/sci_prep.sv =====
// Stages 1 and 2: clear-sky substitution, both absolute departures, mean
// and the signed sigmoid argument product.
module sci_prep
	import sci_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [TEMP_W-1:0]    clear_sky_temp,
	input  logic signed [TEMP_W-1:0]    background_temp,
	input  logic signed [TEMP_W-1:0]    observed_temp,
	input  logic signed [TEMP_W-1:0]    bias_term,
	input  logic                        clear_sky_valid,
	input  logic                        background_valid,
	input  logic                        observed_valid,
	input  logic                        bias_valid,
	input  logic signed [SLOPE_W-1:0]   sigmoid_slope,
	input  logic        [MID_W-1:0]     sigmoid_midpoint,
	output logic                        valid_s2,
	output sci_item_t                   item_s2,
	output logic signed [ARG_PROD_W-1:0] arg_s2
);

	logic signed [TEMP_W-1:0]    clr_use;
	logic signed [SUM_W-1:0]     cmod_raw;
	logic signed [SUM_W-1:0]     cobs_raw;
	logic        [MAG_W-1:0]     cmod_abs;
	logic        [MAG_W-1:0]     cobs_abs;
	logic signed [DEP_RAW_W-1:0] dep_raw;
	logic        [DEP_RAW_W-1:0] dep_abs;
	logic        [DEP_W-1:0]     dep_cap;
	logic signed [DIFF_W-1:0]    diff;
	logic [SUM_W-1:0]            mean_sum;

	logic                        valid_s1;
	logic                        ok_s1;
	logic        [MAG_W-1:0]     cmod_s1;
	logic        [MAG_W-1:0]     cobs_s1;
	logic signed [DIFF_W-1:0]    diff_s1;

	// Clear-sky inside +/-1 K is taken as missing and replaced by background
	always_comb begin
		if (clear_sky_temp > -16'sd64 && clear_sky_temp < 16'sd64) begin
			clr_use = background_temp;
		end else begin
			clr_use = clear_sky_temp;
		end
		cmod_raw = SUM_W'(clr_use) - SUM_W'(background_temp) + SUM_W'(bias_term);
		cobs_raw = SUM_W'(clr_use) - SUM_W'(observed_temp) + SUM_W'(bias_term);
		cmod_abs = cmod_raw[SUM_W-1] ? MAG_W'(-cmod_raw) : MAG_W'(cmod_raw);
		cobs_abs = cobs_raw[SUM_W-1] ? MAG_W'(-cobs_raw) : MAG_W'(cobs_raw);
	end

	// Departure |obs - bak| clamped to 100 K, less the midpoint
	always_comb begin
		dep_raw = DEP_RAW_W'(observed_temp) - DEP_RAW_W'(background_temp);
		dep_abs = dep_raw[DEP_RAW_W-1] ? DEP_RAW_W'(-dep_raw) : DEP_RAW_W'(dep_raw);
		if (dep_abs > DEP_RAW_W'(DEP_CAP)) begin
			dep_cap = DEP_W'(DEP_CAP);
		end else begin
			dep_cap = dep_abs[DEP_W-1:0];
		end
		diff = $signed({{(DIFF_W-DEP_W){1'b0}}, dep_cap})
			- $signed({{(DIFF_W-MID_W){1'b0}}, sigmoid_midpoint});
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1   <= clear_sky_valid & background_valid & observed_valid & bias_valid;
		cmod_s1 <= cmod_abs;
		cobs_s1 <= cobs_abs;
		diff_s1 <= diff;
	end

	// Stage 2: rounded mean and slope product
	assign mean_sum = SUM_W'(cmod_s1) + SUM_W'(cobs_s1) + SUM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s2.ok   <= ok_s1;
		item_s2.mean <= mean_sum[SUM_W-1:1];
		arg_s2       <= ARG_PROD_W'(sigmoid_slope) * ARG_PROD_W'(diff_s1);
	end

endmodule

// ===== rtl/sci_wlookup.sv =====
// Stages 3 and 4: sigmoid table index by reciprocal multiply, then the
// table read with the 0.1 floor.
module sci_wlookup
	import sci_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s2,
	input  sci_item_t                    item_s2,
	input  logic signed [ARG_PROD_W-1:0] arg_s2,
	output logic                         valid_s4,
	output sci_item_t                    item_s4,
	output logic        [WGT_W-1:0]      wgt_s4
);

	logic signed [ARG_W-1:0]       arg_q;
	logic        [SPAN_W-1:0]      span;
	logic [SPAN_W+RECIP_W-1:0]     recip_prod;
	logic        [SIG_IDX_W-1:0]   idx;
	logic        [WGT_W-1:0]       rom_word;

	logic                          valid_s3;
	sci_item_t                     item_s3;
	logic        [SIG_IDX_W-1:0]   idx_s3;

	// floor(n / 2^ARG_SHIFT), then clamp and divide by 25
	always_comb begin
		arg_q      = ARG_W'(arg_s2 >>> ARG_SHIFT);
		span       = SPAN_W'(arg_q + HALF_SPAN);
		recip_prod = (SPAN_W+RECIP_W)'(span) * (SPAN_W+RECIP_W)'(RECIP_K);
		if (arg_q < -HALF_SPAN) begin
			idx = '0;
		end else if (arg_q >= HALF_SPAN) begin
			idx = '1;
		end else begin
			idx = recip_prod[RECIP_SHIFT +: SIG_IDX_W];
		end
	end

	// Stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s3 <= item_s2;
		idx_s3  <= idx;
	end

	// Stage 4: table read, weight floor of 0.1
	assign rom_word = SIG_ROM[idx_s3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		item_s4 <= item_s3;
		wgt_s4  <= (rom_word < WEIGHT_FLOOR) ? WEIGHT_FLOOR : rom_word;
	end

endmodule

// ===== rtl/sci_apply.sv =====
// Stage 5: weight multiply, saturation and the result register.
module sci_apply
	import sci_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 scale_enable,
	input  logic                 valid_s4,
	input  sci_item_t            item_s4,
	input  logic [WGT_W-1:0]     wgt_s4,
	output logic                 done_s5,
	output logic [IMPACT_W-1:0]  impact_s5,
	output logic                 impact_valid_s5
);

	logic [SCALED_W-1:0]  scaled_full;
	logic [MEAN_W-1:0]    scaled;
	logic [MEAN_W-1:0]    pick;
	logic [IMPACT_W-1:0]  sat;

	always_comb begin
		scaled_full = SCALED_W'(item_s4.mean) * SCALED_W'(wgt_s4) + SCALED_W'(ROUND_HALF);
		scaled      = scaled_full[16 +: MEAN_W];
		pick        = scale_enable ? scaled : item_s4.mean;
		if (pick > MEAN_W'(IMPACT_MAX)) begin
			sat = IMPACT_W'(IMPACT_MAX);
		end else begin
			sat = pick[IMPACT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= valid_s4;
		end
	end

	// Missing operand gives zero, flagged invalid
	always_ff @(posedge clk) begin
		impact_valid_s5 <= item_s4.ok;
		impact_s5       <= item_s4.ok ? sat : '0;
	end

endmodule

// ===== test/symmetric_cloud_impact_test.sv =====
module symmetric_cloud_impact_test
	import sci_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Sigmoid argument denominator: 256 (Q8.8) * 6400 counts * 16
	localparam longint ARG_Q = 26214400;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [3:0] ALL_PRESENT = 4'b1111;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 56;

	// One sample set; present bits are {clear_sky, background, observed, bias}
	typedef struct {
		logic signed [TEMP_W-1:0] clr_t;
		logic signed [TEMP_W-1:0] bak_t;
		logic signed [TEMP_W-1:0] obs_t;
		logic signed [TEMP_W-1:0] bias_t;
		logic [3:0]               present;
	} sample_t;

	typedef struct {
		logic [IMPACT_W-1:0] value;
		logic                ok;
	} impact_t;

	// Predicts the impact of each accepted sample set and matches it to the results
	class impact_ledger;
		logic [WGT_W-1:0] weight_rom [SIG_DEPTH];
		bit      scale_on;
		longint  slope_q8;
		longint  midpoint;
		impact_t expected_q [$];
		int      errors;
		int      checked;
		int      missing;
		int      scaled;
		int      saturated;

		function new();
			scale_on  = 1'b0;
			slope_q8  = 256;
			midpoint  = 0;
			errors    = 0;
			checked   = 0;
			missing   = 0;
			scaled    = 0;
			saturated = 0;
			build_weights();
		endfunction

		// Sigmoid at each bin center, Q0.16, from a Taylor series of exp(-x)
		function void build_weights();
			longint          n;
			longint unsigned mag;
			longint unsigned zq;
			longint unsigned frac;
			longint unsigned term;
			longint unsigned e;
			longint unsigned den;
			longint unsigned val;
			for (int i = 0; i < SIG_DEPTH; i++) begin
				n    = 2 * longint'(i) + 1 - longint'(SIG_DEPTH);
				mag  = (n < 0) ? -n : n;
				zq   = (mag << 33) / longint'(SIG_DEPTH);
				frac = zq & (Q30_ONE - 1);
				term = Q30_ONE;
				e    = Q30_ONE;
				for (int k = 1; k <= 16; k++) begin
					term = ((term * frac) >> 30) / k;
					if (k % 2 == 1) begin
						e = e - term;
					end else begin
						e = e + term;
					end
				end
				// one factor of e^-1 per whole unit of |z|
				for (longint unsigned w = 0; w < (zq >> 30); w++) begin
					e = (e * EXP_NEG1_Q30) >> 30;
				end
				den = Q30_ONE + e;
				if (n >= 0) begin
					val = ((64'd1 << 46) + (den >> 1)) / den;
				end else begin
					val = ((e << 16) + (den >> 1)) / den;
				end
				if (val > 64'd65535) begin
					val = 64'd65535;
				end
				weight_rom[i] = val[WGT_W-1:0];
			end
		endfunction

		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_SCALE_ENABLE:     scale_on = data[0];
				CFG_SIGMOID_SLOPE:    slope_q8 = longint'(signed'(data[SLOPE_W-1:0]));
				CFG_SIGMOID_MIDPOINT: midpoint = longint'(data[MID_W-1:0]);
				default: ;
			endcase
		endfunction

		function longint floor_div(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && a < 0) begin
				q = q - 1;
			end
			return q;
		endfunction

		function impact_t predict_impact(sample_t s);
			longint          clr;
			longint          bak;
			longint          obs;
			longint          bias;
			longint          cmod;
			longint          cobs;
			longint          mean;
			longint          dep;
			longint          n;
			longint          idx;
			longint unsigned wgt;
			impact_t         r;
			r.value = '0;
			r.ok    = 1'b0;
			if (s.present != ALL_PRESENT) begin
				return r;
			end
			clr  = s.clr_t;
			bak  = s.bak_t;
			obs  = s.obs_t;
			bias = s.bias_t;
			// clear-sky within one kelvin counts as no cloud signal
			if (clr > -64 && clr < 64) begin
				clr = bak;
			end
			cmod = clr - bak + bias;
			if (cmod < 0) cmod = -cmod;
			cobs = clr - obs + bias;
			if (cobs < 0) cobs = -cobs;
			mean = (cmod + cobs + 1) >> 1;
			if (scale_on) begin
				dep = obs - bak;
				if (dep < 0) dep = -dep;
				if (dep > DEP_CAP) dep = DEP_CAP;
				n   = slope_q8 * (dep - midpoint);
				idx = floor_div(2 * n * SIG_DEPTH + ARG_Q * SIG_DEPTH, 2 * ARG_Q);
				if (idx < 0) idx = 0;
				if (idx > SIG_DEPTH - 1) idx = SIG_DEPTH - 1;
				wgt = weight_rom[idx];
				if (wgt < WEIGHT_FLOOR) wgt = WEIGHT_FLOOR;
				mean = (mean * longint'(wgt) + ROUND_HALF) >> 16;
			end
			if (mean > IMPACT_MAX) mean = IMPACT_MAX;
			r.value = mean[IMPACT_W-1:0];
			r.ok    = 1'b1;
			return r;
		endfunction

		function void note_sample(sample_t s);
			impact_t r;
			r = predict_impact(s);
			expected_q.push_back(r);
			if (!r.ok) begin
				missing++;
			end else begin
				if (scale_on) scaled++;
				if (r.value == IMPACT_MAX) saturated++;
			end
		endfunction

		function void check_result(logic [IMPACT_W-1:0] got, logic got_ok);
			impact_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, impact %0d valid %0b", $time, got, got_ok);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got_ok !== want.ok) begin
				$display("%0t: impact_valid mismatch, expected %0b, got %0b",
					$time, want.ok, got_ok);
				errors++;
			end
			if (got !== want.value) begin
				$display("%0t: impact mismatch, expected %0d, got %0d",
					$time, want.value, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [TEMP_W-1:0]      clear_sky_temp;
	logic [TEMP_W-1:0]      background_temp;
	logic [TEMP_W-1:0]      observed_temp;
	logic [TEMP_W-1:0]      bias_term;
	logic                   clear_sky_valid;
	logic                   background_valid;
	logic                   observed_valid;
	logic                   bias_valid;
	logic                   done;
	logic [IMPACT_W-1:0]    impact;
	logic                   impact_valid;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	impact_ledger ledger;
	int           settings;

	symmetric_cloud_impact DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.clear_sky_temp   (clear_sky_temp),
		.background_temp  (background_temp),
		.observed_temp    (observed_temp),
		.bias_term        (bias_term),
		.clear_sky_valid  (clear_sky_valid),
		.background_valid (background_valid),
		.observed_valid   (observed_valid),
		.bias_valid       (bias_valid),
		.done             (done),
		.impact           (impact),
		.impact_valid     (impact_valid),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result monitor: the strobe cannot be held off, so every one is a transfer
	always @(posedge clk) begin
		if (arst_n && done) begin
			ledger.check_result(impact, impact_valid);
		end
	end

	// Drive one sample set, wait for the transfer, then maybe idle a while
	task automatic send_sample(sample_t s, int idle_pct);
		start            <= 1'b1;
		clear_sky_temp   <= s.clr_t;
		background_temp  <= s.bak_t;
		observed_temp    <= s.obs_t;
		bias_term        <= s.bias_t;
		clear_sky_valid  <= s.present[3];
		background_valid <= s.present[2];
		observed_valid   <= s.present[1];
		bias_valid       <= s.present[0];
		@(posedge clk);
		while (busy) @(posedge clk);
		ledger.note_sample(s);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic issue(int c, int b, int o, int bi, logic [3:0] p);
		sample_t s;
		s.clr_t   = c[TEMP_W-1:0];
		s.bak_t   = b[TEMP_W-1:0];
		s.obs_t   = o[TEMP_W-1:0];
		s.bias_t  = bi[TEMP_W-1:0];
		s.present = p;
		send_sample(s, 0);
	endtask

	task automatic end_burst();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		ledger.apply_write(idx, data);
	endtask

	// Upper data bits above each register are junk; the unused index must change nothing
	task automatic set_registers(bit en, logic [SLOPE_W-1:0] slope, logic [MID_W-1:0] mid);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(CFG_SCALE_ENABLE, {junk[CFG_DATA_W-1:1], en});
		write_reg(CFG_SIGMOID_SLOPE, slope);
		write_reg(CFG_SIGMOID_MIDPOINT, {junk[CFG_DATA_W-1:MID_W], mid});
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		settings++;
	endtask

	// Mostly plausible scenes; some fully random words and some with missing operands
	function automatic sample_t random_sample();
		sample_t s;
		int      kind;
		int      base;
		int      obs;
		int      clr;
		int      bias;
		logic [63:0] bits;
		kind = $urandom_range(99);
		bits = {$urandom, $urandom};
		if (kind < 20) begin
			s.clr_t   = bits[15:0];
			s.bak_t   = bits[31:16];
			s.obs_t   = bits[47:32];
			s.bias_t  = bits[63:48];
			s.present = (kind < 10) ? 4'($urandom) : 4'($urandom_range(0, 14));
		end else begin
			base = int'($urandom_range(0, 24000)) - 4000;
			obs  = base + int'($urandom_range(0, 14000)) - 7000;
			if ($urandom_range(3) == 0) begin
				clr = int'($urandom_range(0, 130)) - 65;
			end else begin
				clr = base - int'($urandom_range(0, 3000));
			end
			bias = $urandom_range(1) ? 0 : int'($urandom_range(0, 800)) - 400;
			s.clr_t   = clr[TEMP_W-1:0];
			s.bak_t   = base[TEMP_W-1:0];
			s.obs_t   = obs[TEMP_W-1:0];
			s.bias_t  = bias[TEMP_W-1:0];
			s.present = ALL_PRESENT;
		end
		return s;
	endfunction

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int idle_pct;
		ledger   = new();
		settings = 1;
		arst_n           <= 1'b0;
		start            <= 1'b0;
		clear_sky_temp   <= '0;
		background_temp  <= '0;
		observed_temp    <= '0;
		bias_term        <= '0;
		clear_sky_valid  <= 1'b0;
		background_valid <= 1'b0;
		observed_valid   <= 1'b0;
		bias_valid       <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, scaling off: missing operands, clear-sky window, saturation
		issue(0, 0, 0, 0, ALL_PRESENT);
		issue(1000, 2000, 3000, 100, 4'b0111);
		issue(1000, 2000, 3000, 100, 4'b1011);
		issue(1000, 2000, 3000, 100, 4'b1101);
		issue(1000, 2000, 3000, 100, 4'b1110);
		issue(1000, 2000, 3000, 100, 4'b0000);
		issue(-63, 500, 800, 0, ALL_PRESENT);
		issue(63, 500, 800, 0, ALL_PRESENT);
		issue(-64, 500, 800, 0, ALL_PRESENT);
		issue(64, 500, 800, 0, ALL_PRESENT);
		issue(32767, -32768, -32768, 32767, ALL_PRESENT);
		issue(-32768, 32767, 32767, -32768, ALL_PRESENT);
		issue(1000, 0, 1, 0, ALL_PRESENT);
		end_burst();
		wait_drained();

		// Scaling on: zero departure, departure at and beyond the cap, both signs
		set_registers(1'b1, SLOPE_RESET, '0);
		issue(15000, 15000, 15000, 0, ALL_PRESENT);
		issue(14000, 15000, 8600, 0, ALL_PRESENT);
		issue(14000, 15000, 1000, -200, ALL_PRESENT);
		issue(14000, 1000, 15000, 200, ALL_PRESENT);
		issue(-32768, 32767, -32768, -32768, ALL_PRESENT);
		issue(20000, 10000, 10500, 0, ALL_PRESENT);
		end_burst();
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_registers(1'b0, 16'($urandom), 13'($urandom));
				1: set_registers(1'b1, SLOPE_RESET, '0);
				2: set_registers(1'b1, 16'h7FFF, 13'd6400);
				3: set_registers(1'b1, 16'h8000, 13'h1FFF);
				4: set_registers(1'b1, '0, 13'($urandom_range(0, 6400)));
				5: set_registers(1'b1, 16'($urandom), 13'($urandom_range(0, 6400)));
				6: set_registers(1'b1, 16'(int'($urandom_range(0, 4096)) - 2048),
					13'($urandom));
				default: set_registers(1'b0, SLOPE_RESET, '0);
			endcase
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 77;
				default: idle_pct = 19;
			endcase
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				send_sample(random_sample(), idle_pct);
				// hold off mid-phase until the pipeline has emptied
				if (p == 4 && j == PHASE_ITEMS / 2) begin
					end_burst();
					wait_drained();
				end
			end
			end_burst();
			wait_drained();
		end

		// Catch any stray result beyond the pipeline depth
		repeat (10) @(posedge clk);
		$display("tb: %0d results checked under %0d register settings", ledger.checked,
			settings);
		$display("tb: %0d with missing operands, %0d sigmoid-weighted, %0d saturated",
			ledger.missing, ledger.scaled, ledger.saturated);
		if (ledger.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sci_pkg.sv
rtl/sci_prep.sv
rtl/sci_wlookup.sv
rtl/sci_apply.sv
rtl/symmetric_cloud_impact.sv
test/symmetric_cloud_impact_test.sv
